/* rtl/cbb_pkg.sv */
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants for the circle boundary bounce step
// Item structs, register indexes, micro-op codes and saturation helper.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int BOUND_REGS = 4;

  // configuration register indexes
  localparam logic [2:0] REG_BOUND_COUNT = 3'd0;
  localparam logic [2:0] REG_BOUND_FIRST = 3'd1;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [30:0] radius;
    logic        [15:0] dt;
  } cbb_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               hit;
    logic        [1:0]  hit_index;
  } cbb_out_t;

  // micro-ops run by the sequencer, one multiply each
  typedef enum logic [3:0] {
    OP_PX, OP_PY,  // predicted position
    OP_DX, OP_DY,  // signed distance at predicted position
    OP_NX, OP_NY,  // impact numerator
    OP_EX, OP_EY,  // impact denominator
    OP_AX, OP_AY,  // move to impact time
    OP_RX, OP_RY,  // reflect velocity
    OP_MX, OP_MY   // move for remaining time
  } cbb_op_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(S32_MAX)) return S32_MAX;
    if (v < 64'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

endpackage

/* rtl/cbb_div.sv */
// ----------------------------------------------------------------------------
// cbb_div: radix-2 restoring divider, 64 / 48 bits, 33 quotient bits
// Flags overflow up front when the quotient needs more than 33 bits.
// ----------------------------------------------------------------------------
module cbb_div import cbb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  output logic        done,
  output logic [32:0] quot,
  output logic        ovf
);

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] pr;
  logic [32:0] dd;
  logic [48:0] trial;
  logic        fits;

  assign trial = {pr, dd[32]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        pr   <= {17'b0, dividend[63:33]};
        dd   <= dividend[32:0];
        quot <= '0;
        cnt  <= 6'd33;
        ovf  <= {17'b0, dividend[63:33]} >= divisor;
        if ({17'b0, dividend[63:33]} >= divisor) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        pr   <= fits ? 48'(trial - {1'b0, divisor}) : trial[47:0];
        quot <= {quot[31:0], fits};
        dd   <= {dd[31:0], 1'b0};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/circle_boundary_bounce_step_core.sv */
// ----------------------------------------------------------------------------
// circle_boundary_bounce_step_core: one fixed-point bounce step per item
// Moves a circle for one time step against up to four half-plane bounds.
// ----------------------------------------------------------------------------
// One item in, one result out. A small sequencer drives a single shared
// 36x33 signed multiplier; every micro-op has a multiply state, then a fold
// into the destination (position and velocity with rounding and 32-bit
// saturation). An item that hits nothing runs the predicted move and one
// distance test per active bound; a hit on a bound adds the impact numerator
// and denominator, the bit-serial divider and the move, reflect and move
// again. in_stall is high while an item is being worked on. The finished
// result sits in an output register, so a new item is taken while the
// previous result still waits on out_stall.
// Bounds are written through the cfg port: index 0 is the active count,
// indexes 1..4 hold normal x (bits 15:0), normal y (31:16), both Q1.14, and
// offset Q16.16 (63:32). Writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module circle_boundary_bounce_step_core import cbb_pkg::*; #(
  parameter int MAX_BOUNDS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cbb_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cbb_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // bounds actually stored and scanned
  localparam int NB = (MAX_BOUNDS < BOUND_REGS) ? MAX_BOUNDS : BOUND_REGS;
  localparam int IW = (NB > 1) ? $clog2(NB) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t  state;
  cbb_op_t op;

  // config
  logic [2:0]  bound_count;
  logic [63:0] bound [NB];

  // working item
  logic signed [31:0] px, py, vx, vy, nxp, nyp;
  logic        [30:0] radius;
  logic        [15:0] dt;
  logic        [IW-1:0] idx;
  logic        hit;

  logic signed [63:0] acc, num, den;
  logic signed [31:0] t;
  logic signed [31:0] rem;
  logic signed [35:0] d2;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod;

  // divider
  logic        div_run, div_start, div_done, div_ovf;
  logic [32:0] div_q;
  logic [63:0] num_abs, den_abs;

  logic [2:0]  nb;
  logic signed [15:0] nx, ny;
  logic signed [63:0] c30;
  logic signed [68:0] r16, r14;
  logic signed [63:0] acc_base, acc_new, pos_sum, vel_sum;
  logic        last;
  logic        out_free;

  // scan min(count, stored bounds)
  assign nb   = (bound_count > 3'(NB)) ? 3'(NB) : bound_count;
  assign last = (4'(idx) + 4'd1) == {1'b0, nb};

  assign nx  = bound[idx][15:0];
  assign ny  = bound[idx][31:16];
  // (offset - radius) in Q.30
  assign c30 = 64'($signed(33'($signed(bound[idx][63:32])) - $signed({2'b0, radius}))) <<< 14;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_count <= '0;
      for (int i = 0; i < NB; i++) begin
        bound[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_BOUND_COUNT) begin
        bound_count <= cfg_data[2:0];
      end
      for (int i = 0; i < NB; i++) begin
        if (cfg_index == REG_BOUND_FIRST + 3'(i)) begin
          bound[i] <= cfg_data;
        end
      end
    end
  end

  // ------------------------------------------------------ operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      OP_PX: begin mul_a = 36'(vx);  mul_b = $signed({17'b0, dt}); end
      OP_PY: begin mul_a = 36'(vy);  mul_b = $signed({17'b0, dt}); end
      OP_DX: begin mul_a = 36'(nxp); mul_b = 33'(nx); end
      OP_DY: begin mul_a = 36'(nyp); mul_b = 33'(ny); end
      OP_NX: begin mul_a = 36'(px);  mul_b = 33'(nx); end
      OP_NY: begin mul_a = 36'(py);  mul_b = 33'(ny); end
      OP_EX: begin mul_a = 36'(vx);  mul_b = 33'(nx); end
      OP_EY: begin mul_a = 36'(vy);  mul_b = 33'(ny); end
      OP_AX: begin mul_a = 36'(vx);  mul_b = 33'(t); end
      OP_AY: begin mul_a = 36'(vy);  mul_b = 33'(t); end
      OP_RX: begin mul_a = d2;       mul_b = 33'(nx); end
      OP_RY: begin mul_a = d2;       mul_b = 33'(ny); end
      OP_MX: begin mul_a = 36'(vx);  mul_b = 33'(rem); end
      OP_MY: begin mul_a = 36'(vy);  mul_b = 33'(rem); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // ---------------------------------------------------------- fold logic
  always_comb begin
    r16 = (prod + 69'sd32768) >>> 16;
    r14 = (prod + 69'sd8192) >>> 14;
    unique case (op)
      OP_DY, OP_NY, OP_EY: acc_base = acc;
      OP_DX, OP_NX:        acc_base = c30;
      default:             acc_base = '0;
    endcase
    acc_new = acc_base + prod[63:0];
    unique case (op)
      OP_PX, OP_AX, OP_MX: pos_sum = 64'(px) + r16[63:0];
      default:             pos_sum = 64'(py) + r16[63:0];
    endcase
    vel_sum = (op == OP_RX) ? 64'(vx) + r14[63:0] : 64'(vy) + r14[63:0];
  end

  // ------------------------------------------------- impact time, reflect
  logic signed [31:0] t_next;
  logic signed [33:0] rem_diff;
  logic signed [63:0] d16;
  logic               t_neg;

  assign num_abs   = num[63] ? 64'(-num) : num;
  assign den_abs   = den[63] ? 64'(-den) : den;
  assign div_start = (state == S_DIV) && !div_run && (den != '0);
  assign t_neg     = (num > 0) != (den < 0);

  always_comb begin
    if (den == '0) begin
      t_next = '0;
    end else if (t_neg) begin
      t_next = (div_ovf || div_q > 33'h0_8000_0000) ? S32_MIN
             : 32'(34'sd0 - $signed({1'b0, div_q}));
    end else begin
      t_next = (div_ovf || div_q > 33'h0_7FFF_FFFF) ? S32_MAX : div_q[31:0];
    end
    rem_diff = $signed({18'b0, dt}) - 34'(t_next);
    d16      = (64'(-den) + 64'sd8192) >>> 14;
  end

  cbb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_abs[47:0], 16'b0}),
    .divisor  (den_abs[47:0]),
    .done     (div_done),
    .quot     (div_q),
    .ovf      (div_ovf)
  );

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_PX;
      out_valid <= 1'b0;
      div_run   <= 1'b0;
    end else begin
      // S_FIN refills the output register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            px     <= in_data.pos_x;
            py     <= in_data.pos_y;
            vx     <= in_data.vel_x;
            vy     <= in_data.vel_y;
            radius <= in_data.radius;
            dt     <= in_data.dt;
            idx    <= '0;
            hit    <= 1'b0;
            op     <= OP_PX;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          unique case (op)
            OP_PX: begin nxp <= sat32(pos_sum); op <= OP_PY; state <= S_MUL; end
            OP_PY: begin
              nyp <= sat32(pos_sum);
              op  <= OP_DX;
              state <= (nb == 3'd0) ? S_FIN : S_MUL;
            end
            OP_DX: begin acc <= acc_new; op <= OP_DY; state <= S_MUL; end
            OP_DY: begin
              if (acc_new <= 0) begin
                op    <= OP_NX;   // first bound touched
                state <= S_MUL;
              end else if (last) begin
                state <= S_FIN;
              end else begin
                idx   <= idx + 1'b1;
                op    <= OP_DX;
                state <= S_MUL;
              end
            end
            OP_NX: begin acc <= acc_new; op <= OP_NY; state <= S_MUL; end
            OP_NY: begin num <= acc_new; op <= OP_EX; state <= S_MUL; end
            OP_EX: begin acc <= acc_new; op <= OP_EY; state <= S_MUL; end
            OP_EY: begin
              den   <= acc_new;
              state <= S_DIV;
            end
            OP_AX: begin px <= sat32(pos_sum); op <= OP_AY; state <= S_MUL; end
            OP_AY: begin py <= sat32(pos_sum); op <= OP_RX; state <= S_MUL; end
            OP_RX: begin vx <= sat32(vel_sum); op <= OP_RY; state <= S_MUL; end
            OP_RY: begin vy <= sat32(vel_sum); op <= OP_MX; state <= S_MUL; end
            OP_MX: begin nxp <= sat32(pos_sum); op <= OP_MY; state <= S_MUL; end
            OP_MY: begin
              nyp   <= sat32(pos_sum);
              hit   <= 1'b1;
              state <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_DIV: begin
          if (den == '0 || div_done) begin
            div_run <= 1'b0;
            t       <= t_next;
            // remaining time clamped to [0, 2^31-1]
            if (rem_diff < 0) begin
              rem <= '0;
            end else if (rem_diff > 34'(S32_MAX)) begin
              rem <= S32_MAX;
            end else begin
              rem <= rem_diff[31:0];
            end
            d2    <= 36'(d16 <<< 1);
            op    <= OP_AX;
            state <= S_MUL;
          end else if (div_start) begin
            div_run <= 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data.new_pos_x <= nxp;
            out_data.new_pos_y <= nyp;
            out_data.new_vel_x <= vx;
            out_data.new_vel_y <= vy;
            out_data.hit       <= hit;
            out_data.hit_index <= hit ? 2'(idx) : 2'd0;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/cbb_checker.sv */
// ----------------------------------------------------------------------------
// cbb_checker: port-level checks for the bounce step core
// Bound to the top level; watches handshakes and result coding.
// ----------------------------------------------------------------------------
module cbb_checker import cbb_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input cbb_out_t out_data
);

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // no hit means the index reads zero
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> (out_data.hit_index == 2'd0))
    else $error("hit_index set without a hit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind circle_boundary_bounce_step_core cbb_checker u_cbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* verif/circle_boundary_bounce_step_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_boundary_bounce_step_core_tb: self-checking bench for the bounce step
// Drives directed and random circles against several bound setups, predicts
// each result in the bench and checks every result field by field.
// ----------------------------------------------------------------------------
module circle_boundary_bounce_step_core_tb;
  import cbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int PHASE_ITEMS    = 108;
  localparam int NUM_PHASES     = 6;
  localparam logic [15:0] N_ONE  = 16'sd16384;   // 1.0 in Q1.14
  localparam logic [15:0] N_DIAG = 16'sd11585;   // ~0.7071 in Q1.14

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cbb_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  cbb_out_t    out_data;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = REG_BOUND_COUNT;
  logic [63:0] cfg_data = '0;

  circle_boundary_bounce_step_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // bench copy of the bound registers
  logic [2:0]  active_bounds = '0;
  logic [63:0] bound_word [BOUND_REGS];

  cbb_in_t  pending_items [$];
  cbb_out_t expected_moves [$];
  logic     feed_hold = 1'b1;
  logic     in_taken = 1'b0;
  int       send_idle = 0, recv_idle = 0;
  int       items_sent = 0, results_seen = 0, hits_seen = 0;
  int       mismatches = 0, quiet_cycles = 0;

  initial forever #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // floor((x + 2^(k-1)) / 2^k)
  function automatic longint round_shift(longint x, int k);
    longint y;
    y = x + (longint'(1) << (k - 1));
    return y >>> k;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint move_by(longint p, longint v, longint s);
    return clamp32(p + round_shift(v * s, 16));
  endfunction

  function automatic cbb_out_t bounce_predict(cbb_in_t it);
    cbb_out_t res;
    longint px, py, vx, vy, rad, dts, nxp, nyp;
    longint nx, ny, c30, gap, num, den, t, rem, d16;
    longint unsigned mn, md, q;
    logic neg;
    int scan;
    px = it.pos_x; py = it.pos_y; vx = it.vel_x; vy = it.vel_y;
    rad = longint'(it.radius); dts = longint'(it.dt);
    nxp = move_by(px, vx, dts);
    nyp = move_by(py, vy, dts);
    res = '0;
    // counts above four still scan only four bounds
    scan = (active_bounds > 3'd4) ? 4 : int'(active_bounds);
    for (int i = 0; i < scan; i++) begin
      nx = longint'($signed(bound_word[i][15:0]));
      ny = longint'($signed(bound_word[i][31:16]));
      c30 = (longint'($signed(bound_word[i][63:32])) - rad) * 16384;
      gap = nx * nxp + ny * nyp + c30;
      if (gap <= 0 && !res.hit) begin
        num = nx * px + ny * py + c30;
        den = nx * vx + ny * vy;
        t = 0;                       // parallel motion: impact at time zero
        if (den != 0) begin
          neg = ((-num) < 0) != (den < 0);
          mn = (num < 0) ? -num : num;
          mn = mn << 16;
          md = (den < 0) ? -den : den;
          q = mn / md;
          if (neg) t = (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
          else     t = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
        end
        px = move_by(px, vx, t);
        py = move_by(py, vy, t);
        // a negative impact time lengthens what is left of the step, clamped to [0, 2^31-1]
        rem = dts - t;
        if (rem < 0) rem = 0;
        if (rem > 64'sh7FFF_FFFF) rem = 64'sh7FFF_FFFF;
        d16 = round_shift(nx * (-vx) + ny * (-vy), 14);
        vx = clamp32(round_shift(2 * d16 * nx, 14) + vx);
        vy = clamp32(round_shift(2 * d16 * ny, 14) + vy);
        nxp = move_by(px, vx, rem);
        nyp = move_by(py, vy, rem);
        res.hit = 1'b1;
        res.hit_index = i[1:0];
      end
    end
    res.new_pos_x = nxp[31:0];
    res.new_pos_y = nyp[31:0];
    res.new_vel_x = vx[31:0];
    res.new_vel_y = vy[31:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs move on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      // a held item stays put until it is taken
      if (!in_valid || in_taken) begin
        if (!feed_hold && pending_items.size() > 0 &&
            $urandom_range(99) >= send_idle) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor, scoreboard and watchdog: sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cbb_out_t want;
    in_taken <= in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_moves.push_back(bounce_predict(in_data));
        items_sent++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.hit) hits_seen++;
        if (expected_moves.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result %h", out_data);
        end else begin
          want = expected_moves.pop_front();
          if (out_data.new_pos_x !== want.new_pos_x ||
              out_data.new_pos_y !== want.new_pos_y ||
              out_data.new_vel_x !== want.new_vel_x ||
              out_data.new_vel_y !== want.new_vel_y ||
              out_data.hit !== want.hit || out_data.hit_index !== want.hit_index) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d pos (%h,%h) vel (%h,%h) hit %b idx %0d",
                       results_seen, out_data.new_pos_x, out_data.new_pos_y,
                       out_data.new_vel_x, out_data.new_vel_y,
                       out_data.hit, out_data.hit_index);
              $display("       expected pos (%h,%h) vel (%h,%h) hit %b idx %0d",
                       want.new_pos_x, want.new_pos_y, want.new_vel_x,
                       want.new_vel_y, want.hit, want.hit_index);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no handshake for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // cfg writes happen only while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_BOUND_COUNT) active_bounds = val[2:0];
    else if (idx <= 3'(BOUND_REGS)) bound_word[2'(idx - REG_BOUND_FIRST)] = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // release the queue, then hold off until every result is back and settled;
  // checked just after the falling edge, once the driver has updated
  task automatic run_and_drain();
    feed_hold = 1'b0;
    do begin
      @(negedge clk);
      #1;
    end while (pending_items.size() > 0 || in_valid || expected_moves.size() > 0);
    feed_hold = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic cbb_in_t make_item(int px, int py, int vx, int vy,
                                        logic [30:0] rad, logic [15:0] dts);
    cbb_in_t it;
    it.pos_x = px; it.pos_y = py; it.vel_x = vx; it.vel_y = vy;
    it.radius = rad; it.dt = dts;
    return it;
  endfunction

  // axis box of half width hw (whole units), diagonal or junk walls mixed in
  task automatic load_bounds(input logic [2:0] count, input int hw);
    logic [63:0] w;
    logic [31:0] off;
    off = hw << 16;
    for (int i = 0; i < BOUND_REGS; i++) begin
      case ($urandom_range(9))
        0: w = {$urandom, $urandom};
        1: w = {off, (i[0] ? -N_DIAG : N_DIAG), (i[1] ? -N_DIAG : N_DIAG)};
        default: begin
          case (i)
            0: w = {off, 16'sd0, N_ONE};
            1: w = {off, 16'sd0, -N_ONE};
            2: w = {off, N_ONE, 16'sd0};
            default: w = {off, -N_ONE, 16'sd0};
          endcase
        end
      endcase
      write_reg(REG_BOUND_FIRST + 3'(i), w);
    end
    write_reg(REG_BOUND_COUNT, {61'd0, count});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int hw, kind, span, vmax;
    logic [2:0] phase_count [NUM_PHASES];
    phase_count = '{3'd4, 3'd7, 3'd2, 3'd0, 3'd3, 3'd4};
    for (int i = 0; i < BOUND_REGS; i++) bound_word[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // writes past the last bound register must be dropped
    write_reg(3'd5, {$urandom, $urandom});
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);

    // directed: box of half width 100, all four walls live
    for (int i = 0; i < BOUND_REGS; i++) begin
      case (i)
        0: write_reg(REG_BOUND_FIRST, {32'd100 << 16, 16'sd0, N_ONE});
        1: write_reg(REG_BOUND_FIRST + 3'd1, {32'd100 << 16, 16'sd0, -N_ONE});
        2: write_reg(REG_BOUND_FIRST + 3'd2, {32'd100 << 16, N_ONE, 16'sd0});
        default: write_reg(REG_BOUND_FIRST + 3'd3, {32'd100 << 16, -N_ONE, 16'sd0});
      endcase
    end
    write_reg(REG_BOUND_COUNT, 64'd4);
    send_idle = 15; recv_idle = 65;
    pending_items.push_back(make_item(0, 0, 0, 0, '0, '0));
    pending_items.push_back(make_item(0, 0, 1 << 16, -(3 << 16), 31'(2 << 16), 16'hFFFF));
    // extreme positions at rest: wall hit with zero velocity (parallel case)
    pending_items.push_back(make_item(32'h7FFF_FFFF, 0, 0, 0, '0, 16'h8000));
    pending_items.push_back(make_item(0, 32'h8000_0000, 0, 0, '0, 16'h8000));
    pending_items.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, '1, 16'hFFFF));
    // extreme velocities
    pending_items.push_back(make_item(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, '0, 16'hFFFF));
    pending_items.push_back(make_item(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, '1, 16'hFFFF));
    pending_items.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 16'hFFFF));
    // ordinary wall strikes on each side
    pending_items.push_back(make_item(90 << 16, 0, 50 << 16, 0, 31'(5 << 16), 16'h8000));
    pending_items.push_back(make_item(-(90 << 16), 0, -(50 << 16), 0, 31'(5 << 16), 16'h8000));
    pending_items.push_back(make_item(0, 90 << 16, 3 << 16, 80 << 16, 31'(5 << 16), 16'h8000));
    pending_items.push_back(make_item(0, -(90 << 16), 0, -(80 << 16), 31'(5 << 16), 16'hC000));
    pending_items.push_back(make_item(95 << 16, 95 << 16, 70 << 16, 70 << 16, 31'(1 << 16), 16'hFFFF));
    // already inside the wall: moving out gives a negative impact time, moving back in a positive one
    pending_items.push_back(make_item(32'h0063_8000, 0, 10 << 16, 0, 31'(5 << 16), 16'h4000));
    pending_items.push_back(make_item(32'h0063_8000, 0, -(10 << 16), 5 << 16, 31'(5 << 16), 16'h4000));
    // zero time step, and the smallest nonzero one
    pending_items.push_back(make_item(96 << 16, 0, 10 << 16, 0, 31'(5 << 16), 16'h0000));
    pending_items.push_back(make_item(96 << 16, 0, 10 << 16, 0, 31'(5 << 16), 16'h0001));
    pending_items.push_back(make_item(-1, -1, -1, -1, 31'h0000_0001, 16'h0001));
    run_and_drain();

    // random phases, each with a fresh bound setup
    for (int p = 0; p < NUM_PHASES; p++) begin
      hw = $urandom_range(1000, 1);
      load_bounds(phase_count[p], hw);
      case (p / 2)
        0: begin send_idle = 15; recv_idle = 65; end
        1: begin send_idle = 65; recv_idle = 15; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      span = hw << 16;
      vmax = hw * 4 << 16;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(99);
        if (kind < 70)
          pending_items.push_back(make_item(
            $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
            $urandom_range(2 * vmax) - vmax, $urandom_range(2 * vmax) - vmax,
            31'($urandom_range(hw << 15)), 16'($urandom)));
        else
          pending_items.push_back(make_item($urandom, $urandom, $urandom, $urandom,
                                            31'($urandom), 16'($urandom)));
      end
      run_and_drain();
    end

    $display("Covered %0d items (%0d wall hits) over %0d bound setups,",
             items_sent, hits_seen, NUM_PHASES + 1);
    $display("with counts from zero to seven and both sides stalling in turn.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
